>>> src/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the cell allocator with compaction.
// ----------------------------------------------------------------------------
package cca_pkg;

  localparam int MODE_W   = 2;
  localparam int TAG_W    = 8;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 3;
  localparam int START_W  = 6;
  localparam int SWAP_W   = 7;

  localparam logic [TAG_W-1:0] FREE_CODE = 8'd32;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 2'd0,
    MODE_DEL     = 2'd1,
    MODE_COMPACT = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EXISTS   = 3'd1,
    STAT_NOSPACE  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_INVALID  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_EV,
    ST_ADD_DEC,
    ST_FILL_RD,
    ST_FILL_EV,
    ST_DEL_RD,
    ST_DEL_EV,
    ST_RESP,
    ST_ORD_RD,
    ST_ORD_EV,
    ST_SEEN_RD,
    ST_SEEN_EV,
    ST_FILE_RD,
    ST_FILE_EV,
    ST_CNT_RD,
    ST_CNT_EV,
    ST_POS,
    ST_POS_EV,
    ST_SRCH_RD,
    ST_SRCH_EV,
    ST_SWAP,
    ST_EMIT
  } state_e;

endpackage

>>> src/cca_ram.sv
// ----------------------------------------------------------------------------
// cca_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cell_allocator_with_compaction.sv
// ----------------------------------------------------------------------------
// cell_allocator_with_compaction
// First-fit cell store with add, delete and compaction, sequenced over a
// cell RAM and a file order RAM.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o| mode_i, tag_i, length_i
//   out     | output    | out_valid_o/out_stall_i| status_o, file_tag_o,
//           |           |                        | start_cell_o, swap_count_o,
//           |           |                        | last_o
//
// Each cell access is a read state then an evaluate state on the cell RAM.
// Add: two passes over the store, delete: one pass. Compact: an order build
// that checks each used cell against the files seen so far, then per file
// one count pass plus a forward search per misplaced cell.
// Reset marks every cell free through per-cell valid flags; no clearing pass.
// A new request is taken once the previous one has its results registered;
// a stalled output only holds the sequencer when the next result is ready.
// ----------------------------------------------------------------------------
module cell_allocator_with_compaction #(
  parameter int NUM_CELLS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] tag_i,
  input  logic [6:0] length_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] file_tag_o,
  output logic [5:0] start_cell_o,
  output logic [6:0] swap_count_o,
  output logic       last_o
);

  localparam int AW     = $clog2(NUM_CELLS);
  localparam int CW     = $clog2(NUM_CELLS + 1);
  localparam int TagW   = cca_pkg::TAG_W;
  localparam int LenW   = cca_pkg::LEN_W;
  localparam int StartW = cca_pkg::START_W;
  localparam int SwapW  = cca_pkg::SWAP_W;

  localparam logic [CW-1:0] LastIdx = CW'(NUM_CELLS - 1);
  localparam logic [CW-1:0] NumC    = CW'(NUM_CELLS);

  cca_pkg::state_e  state_q, state_d;
  cca_pkg::mode_e   mode_q, mode_d;
  cca_pkg::status_e stat_q, stat_d;

  logic [TagW-1:0]   tag_q, tag_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [CW-1:0]     i_q, i_d;
  logic [CW-1:0]     j_q, j_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     nfiles_q, nfiles_d;
  logic [CW-1:0]     f_q, f_d;
  logic [CW-1:0]     p_q, p_d;
  logic [CW-1:0]     z_q, z_d;
  logic [StartW-1:0] start_q, start_d;
  logic [SwapW-1:0]  swaps_q, swaps_d;
  logic [TagW-1:0]   t_q, t_d;
  logic [TagW-1:0]   hold_q, hold_d;
  logic              found_q, found_d;

  logic [NUM_CELLS-1:0] valid_q;
  logic                 rd_vld_q;

  logic            cram_we, cram_re;
  logic [AW-1:0]   cram_waddr, cram_raddr;
  logic [TagW-1:0] cram_wdata, cram_rdata;
  logic            oram_we, oram_re;
  logic [AW-1:0]   oram_waddr, oram_raddr;
  logic [TagW-1:0] oram_wdata, oram_rdata;

  logic [TagW-1:0] cell_val;
  logic            ord_next;

  logic              out_valid_q;
  cca_pkg::status_e  out_stat_q, ld_stat;
  logic [TagW-1:0]   out_tag_q, ld_tag;
  logic [StartW-1:0] out_start_q, ld_start;
  logic [SwapW-1:0]  out_swap_q, ld_swap;
  logic              out_last_q, ld_last;
  logic              out_load, slot_free;

  cca_ram #(.WIDTH(TagW), .DEPTH(NUM_CELLS)) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cram_we),
    .waddr_i(cram_waddr),
    .wdata_i(cram_wdata),
    .re_i   (cram_re),
    .raddr_i(cram_raddr),
    .rdata_o(cram_rdata)
  );

  cca_ram #(.WIDTH(TagW), .DEPTH(NUM_CELLS)) u_order_ram (
    .clk_i  (clk_i),
    .we_i   (oram_we),
    .waddr_i(oram_waddr),
    .wdata_i(oram_wdata),
    .re_i   (oram_re),
    .raddr_i(oram_raddr),
    .rdata_o(oram_rdata)
  );

  assign cell_val  = rd_vld_q ? cram_rdata : cca_pkg::FREE_CODE;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    stat_d     = stat_q;
    tag_d      = tag_q;
    len_d      = len_q;
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    nfiles_d   = nfiles_q;
    f_d        = f_q;
    p_d        = p_q;
    z_d        = z_q;
    start_d    = start_q;
    swaps_d    = swaps_q;
    t_d        = t_q;
    hold_d     = hold_q;
    found_d    = found_q;
    cram_we    = 1'b0;
    cram_waddr = i_q[AW-1:0];
    cram_wdata = tag_q;
    cram_re    = 1'b0;
    cram_raddr = i_q[AW-1:0];
    oram_we    = 1'b0;
    oram_waddr = nfiles_q[AW-1:0];
    oram_wdata = t_q;
    oram_re    = 1'b0;
    oram_raddr = j_q[AW-1:0];
    ord_next   = 1'b0;
    out_load   = 1'b0;
    ld_stat    = stat_q;
    ld_tag     = tag_q;
    ld_start   = '0;
    ld_swap    = '0;
    ld_last    = 1'b1;

    case (state_q)
      cca_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = cca_pkg::mode_e'(mode_i);
          tag_d   = tag_i;
          len_d   = length_i;
          i_d     = '0;
          cnt_d   = '0;
          found_d = 1'b0;
          case (cca_pkg::mode_e'(mode_i))
            cca_pkg::MODE_ADD, cca_pkg::MODE_DEL: begin
              if (tag_i == cca_pkg::FREE_CODE) begin
                stat_d  = cca_pkg::STAT_INVALID;
                state_d = cca_pkg::ST_RESP;
              end else if (cca_pkg::mode_e'(mode_i) == cca_pkg::MODE_ADD) begin
                state_d = cca_pkg::ST_ADD_RD;
              end else begin
                state_d = cca_pkg::ST_DEL_RD;
              end
            end
            cca_pkg::MODE_COMPACT: begin
              nfiles_d = '0;
              state_d  = cca_pkg::ST_ORD_RD;
            end
            default: begin
              state_d = cca_pkg::ST_IDLE;
            end
          endcase
        end
      end
      cca_pkg::ST_ADD_RD: begin
        cram_re = 1'b1;
        state_d = cca_pkg::ST_ADD_EV;
      end
      cca_pkg::ST_ADD_EV: begin
        if (cell_val == cca_pkg::FREE_CODE) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (cell_val == tag_q) begin
          found_d = 1'b1;
        end
        if (i_q == LastIdx) begin
          state_d = cca_pkg::ST_ADD_DEC;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = cca_pkg::ST_ADD_RD;
        end
      end
      cca_pkg::ST_ADD_DEC: begin
        i_d = '0;
        if (LenW'(cnt_q) < len_q) begin
          stat_d  = cca_pkg::STAT_NOSPACE;
          state_d = cca_pkg::ST_RESP;
        end else if (found_q) begin
          stat_d  = cca_pkg::STAT_EXISTS;
          state_d = cca_pkg::ST_RESP;
        end else if (len_q == '0) begin
          stat_d  = cca_pkg::STAT_OK;
          state_d = cca_pkg::ST_RESP;
        end else begin
          z_d     = CW'(len_q);
          state_d = cca_pkg::ST_FILL_RD;
        end
      end
      cca_pkg::ST_FILL_RD: begin
        cram_re = 1'b1;
        state_d = cca_pkg::ST_FILL_EV;
      end
      cca_pkg::ST_FILL_EV: begin
        if (cell_val == cca_pkg::FREE_CODE) begin
          cram_we = 1'b1;
          z_d     = z_q - 1'b1;
        end
        if (((cell_val == cca_pkg::FREE_CODE) && (z_q == CW'(1))) ||
            (i_q == LastIdx)) begin
          stat_d  = cca_pkg::STAT_OK;
          state_d = cca_pkg::ST_RESP;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = cca_pkg::ST_FILL_RD;
        end
      end
      cca_pkg::ST_DEL_RD: begin
        cram_re = 1'b1;
        state_d = cca_pkg::ST_DEL_EV;
      end
      cca_pkg::ST_DEL_EV: begin
        if (cell_val == tag_q) begin
          cram_we    = 1'b1;
          cram_wdata = cca_pkg::FREE_CODE;
          found_d    = 1'b1;
        end
        if (i_q == LastIdx) begin
          stat_d  = (found_q || (cell_val == tag_q)) ?
                    cca_pkg::STAT_OK : cca_pkg::STAT_NOTFOUND;
          state_d = cca_pkg::ST_RESP;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = cca_pkg::ST_DEL_RD;
        end
      end
      cca_pkg::ST_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = cca_pkg::ST_IDLE;
        end
      end
      cca_pkg::ST_ORD_RD: begin
        cram_re = 1'b1;
        state_d = cca_pkg::ST_ORD_EV;
      end
      cca_pkg::ST_ORD_EV: begin
        if (cell_val == cca_pkg::FREE_CODE) begin
          ord_next = 1'b1;
        end else begin
          t_d     = cell_val;
          j_d     = '0;
          state_d = cca_pkg::ST_SEEN_RD;
        end
      end
      cca_pkg::ST_SEEN_RD: begin
        if (j_q == nfiles_q) begin
          oram_we  = 1'b1;
          nfiles_d = nfiles_q + 1'b1;
          ord_next = 1'b1;
        end else begin
          oram_re = 1'b1;
          state_d = cca_pkg::ST_SEEN_EV;
        end
      end
      cca_pkg::ST_SEEN_EV: begin
        if (oram_rdata == t_q) begin
          ord_next = 1'b1;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = cca_pkg::ST_SEEN_RD;
        end
      end
      cca_pkg::ST_FILE_RD: begin
        oram_re    = 1'b1;
        oram_raddr = f_q[AW-1:0];
        state_d    = cca_pkg::ST_FILE_EV;
      end
      cca_pkg::ST_FILE_EV: begin
        t_d     = oram_rdata;
        i_d     = '0;
        cnt_d   = '0;
        state_d = cca_pkg::ST_CNT_RD;
      end
      cca_pkg::ST_CNT_RD: begin
        cram_re = 1'b1;
        state_d = cca_pkg::ST_CNT_EV;
      end
      cca_pkg::ST_CNT_EV: begin
        if (cell_val == t_q) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (i_q == LastIdx) begin
          z_d     = '0;
          start_d = StartW'(p_q);
          state_d = cca_pkg::ST_POS;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = cca_pkg::ST_CNT_RD;
        end
      end
      cca_pkg::ST_POS: begin
        if ((z_q < cnt_q) && (p_q < NumC)) begin
          cram_re    = 1'b1;
          cram_raddr = p_q[AW-1:0];
          state_d    = cca_pkg::ST_POS_EV;
        end else begin
          state_d = cca_pkg::ST_EMIT;
        end
      end
      cca_pkg::ST_POS_EV: begin
        if (cell_val == t_q) begin
          p_d     = p_q + 1'b1;
          z_d     = z_q + 1'b1;
          state_d = cca_pkg::ST_POS;
        end else begin
          hold_d  = cell_val;
          j_d     = p_q + 1'b1;
          state_d = cca_pkg::ST_SRCH_RD;
        end
      end
      cca_pkg::ST_SRCH_RD: begin
        if (j_q == NumC) begin
          p_d     = p_q + 1'b1;
          z_d     = z_q + 1'b1;
          state_d = cca_pkg::ST_POS;
        end else begin
          cram_re    = 1'b1;
          cram_raddr = j_q[AW-1:0];
          state_d    = cca_pkg::ST_SRCH_EV;
        end
      end
      cca_pkg::ST_SRCH_EV: begin
        if (cell_val == t_q) begin
          cram_we    = 1'b1;
          cram_waddr = p_q[AW-1:0];
          cram_wdata = t_q;
          state_d    = cca_pkg::ST_SWAP;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = cca_pkg::ST_SRCH_RD;
        end
      end
      cca_pkg::ST_SWAP: begin
        cram_we    = 1'b1;
        cram_waddr = j_q[AW-1:0];
        cram_wdata = hold_q;
        swaps_d    = swaps_q + 1'b1;
        p_d        = p_q + 1'b1;
        z_d        = z_q + 1'b1;
        state_d    = cca_pkg::ST_POS;
      end
      cca_pkg::ST_EMIT: begin
        ld_stat  = cca_pkg::STAT_OK;
        ld_tag   = t_q;
        ld_start = start_q;
        ld_swap  = swaps_q;
        ld_last  = ((f_q + 1'b1) == nfiles_q);
        if (slot_free) begin
          out_load = 1'b1;
          if ((f_q + 1'b1) == nfiles_q) begin
            state_d = cca_pkg::ST_IDLE;
          end else begin
            f_d     = f_q + 1'b1;
            state_d = cca_pkg::ST_FILE_RD;
          end
        end
      end
      default: begin
        state_d = cca_pkg::ST_IDLE;
      end
    endcase

    if (ord_next) begin
      if (i_q == LastIdx) begin
        if (nfiles_d == '0) begin
          stat_d  = cca_pkg::STAT_OK;
          tag_d   = cca_pkg::FREE_CODE;
          state_d = cca_pkg::ST_RESP;
        end else begin
          f_d     = '0;
          p_d     = '0;
          swaps_d = '0;
          state_d = cca_pkg::ST_FILE_RD;
        end
      end else begin
        i_d     = i_q + 1'b1;
        state_d = cca_pkg::ST_ORD_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cca_pkg::ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cram_we) begin
        valid_q[cram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    stat_q   <= stat_d;
    tag_q    <= tag_d;
    len_q    <= len_d;
    i_q      <= i_d;
    j_q      <= j_d;
    cnt_q    <= cnt_d;
    nfiles_q <= nfiles_d;
    f_q      <= f_d;
    p_q      <= p_d;
    z_q      <= z_d;
    start_q  <= start_d;
    swaps_q  <= swaps_d;
    t_q      <= t_d;
    hold_q   <= hold_d;
    found_q  <= found_d;
    if (cram_re) begin
      rd_vld_q <= valid_q[cram_raddr];
    end
    if (out_load) begin
      out_stat_q  <= ld_stat;
      out_tag_q   <= ld_tag;
      out_start_q <= ld_start;
      out_swap_q  <= ld_swap;
      out_last_q  <= ld_last;
    end
  end

  assign in_stall_o   = (state_q != cca_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_stat_q;
  assign file_tag_o   = out_tag_q;
  assign start_cell_o = out_start_q;
  assign swap_count_o = out_swap_q;
  assign last_o       = out_last_q;

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cram_we && cram_re |-> cram_waddr != cram_raddr)
    else $error("cell RAM read and write hit the same entry");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_swaps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cca_pkg::ST_FILE_RD |-> 32'(swaps_q) <= 32'(p_q))
    else $error("swap count exceeds packed cells");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i != cca_pkg::MODE_NONE)
      |=> state_q != cca_pkg::ST_IDLE)
    else $error("accepted request did not start");

endmodule
